>>> design/mdm_pkg.sv
package mdm_pkg;

    // Drive range after the stick clamp
    localparam int FULL_DRIVE = 255;
    localparam int HALF_DRIVE = 128;

    // Governor: limit = floor(pct * 255 / 100), done as a reciprocal multiply
    localparam logic [6:0]  PCT_MAX     = 7'd100;
    localparam logic [12:0] LIM_RECIP   = 13'd5243;
    localparam int          LIM_SHIFT   = 19;
    localparam logic [6:0]  PCT_RESET   = 7'd100;
    localparam logic [7:0]  LIM_RESET   = 8'd255;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Mixing modes picked by the front
    typedef enum logic [1:0] {
        MODE_SPIN,
        MODE_SLIDE,
        MODE_VEER,
        MODE_PROPEL
    } mdm_mode_t;

    // Classified item handed from front to back
    typedef struct packed {
        mdm_mode_t          mode;
        logic signed [8:0]  y;          // governed y
        logic signed [8:0]  xg;         // governed x, used when y is zero
        logic [7:0]         factor;     // scale factor for one side
        logic               div128;     // divide by 128 instead of 255
        logic               neg;        // negate the scaled side
        logic               scale_en;   // one side gets scaled
        logic               scale_left; // the scaled side is the left one
    } mdm_item_t;

endpackage

>>> design/mdm_front.sv
module mdm_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr,
    input  logic [6:0]              cfg_pct,
    input  logic                    push,
    input  logic                    full,
    input  logic signed [15:0]      axis_x,
    input  logic signed [15:0]      axis_y,
    input  logic                    strafe_mode,
    output logic                    item_wr,
    output mdm_pkg::mdm_item_t      item
);

    logic [7:0]         lim_reg;
    logic [7:0]         lim_next;
    logic [6:0]         pct_sat;
    logic [14:0]        pct_x255;
    logic [27:0]        lim_prod;
    logic signed [8:0]  x_c;
    logic signed [8:0]  y_c;
    logic signed [9:0]  lim_s;
    logic signed [8:0]  y_g;
    logic signed [8:0]  x_g;
    logic [7:0]         ax;

    // Work out the governor limit from the written percentage
    always_comb
    begin
        pct_sat  = (cfg_pct > mdm_pkg::PCT_MAX) ? mdm_pkg::PCT_MAX : cfg_pct;
        pct_x255 = {pct_sat, 8'd0} - {8'd0, pct_sat};
        lim_prod = {13'd0, pct_x255} * {15'd0, mdm_pkg::LIM_RECIP};
        lim_next = lim_prod[mdm_pkg::LIM_SHIFT +: 8];
    end

    // Hold the limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= mdm_pkg::LIM_RESET;
        end
        else if (cfg_wr)
        begin
            lim_reg <= lim_next;
        end
    end

    // Clamp both axes, then govern y and x
    always_comb
    begin
        if (axis_x > 16'sd255)
            x_c = 9'sd255;
        else if (axis_x < -16'sd255)
            x_c = -9'sd255;
        else
            x_c = axis_x[8:0];

        if (axis_y > 16'sd255)
            y_c = 9'sd255;
        else if (axis_y < -16'sd255)
            y_c = -9'sd255;
        else
            y_c = axis_y[8:0];

        lim_s = $signed({2'b00, lim_reg});

        if (10'(y_c) > lim_s)
            y_g = lim_s[8:0];
        else if (10'(y_c) < -lim_s)
            y_g = 9'(-lim_s);
        else
            y_g = y_c;

        if (10'(x_c) > lim_s)
            x_g = lim_s[8:0];
        else if (10'(x_c) < -lim_s)
            x_g = 9'(-lim_s);
        else
            x_g = x_c;

        ax = x_c[8] ? 8'(-x_c) : x_c[7:0];
    end

    // Classify the item
    always_comb
    begin
        item.y          = y_g;
        item.xg         = x_g;
        item.factor     = 8'(mdm_pkg::FULL_DRIVE) - ax;
        item.div128     = 1'b0;
        item.neg        = 1'b0;
        item.scale_en   = 1'b0;
        item.scale_left = x_c[8];
        if (y_g == 9'sd0)
        begin
            item.mode = strafe_mode ? mdm_pkg::MODE_SLIDE : mdm_pkg::MODE_SPIN;
        end
        else if (!strafe_mode)
        begin
            item.mode     = mdm_pkg::MODE_VEER;
            item.scale_en = (ax != 8'd0);
        end
        else
        begin
            item.mode     = mdm_pkg::MODE_PROPEL;
            item.div128   = 1'b1;
            item.scale_en = (ax != 8'd0) && (ax != 8'(mdm_pkg::FULL_DRIVE));
            if (ax > 8'(mdm_pkg::HALF_DRIVE))
            begin
                item.neg = 1'b1;
            end
            else
            begin
                item.factor = 8'(mdm_pkg::HALF_DRIVE) - ax;
            end
        end
    end

    assign item_wr = push && !full;

endmodule

>>> design/mdm_queue.sv
module mdm_queue
#(
    parameter int DEPTH = mdm_pkg::QUEUE_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr,
    input  mdm_pkg::mdm_item_t      wr_item,
    output logic                    full,
    input  logic                    rd,
    output logic                    rd_valid,
    output mdm_pkg::mdm_item_t      rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mdm_pkg::mdm_item_t     slot_reg [DEPTH];
    logic [PTR_W-1:0]       wptr_reg;
    logic [PTR_W-1:0]       wptr_next;
    logic [PTR_W-1:0]       rptr_reg;
    logic [PTR_W-1:0]       rptr_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic                   do_wr;
    logic                   do_rd;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = slot_reg[rptr_reg];
    assign do_wr    = wr && !full;
    assign do_rd    = rd && rd_valid;

    // Advance pointers and count
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr)
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        if (do_rd)
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Store the incoming item
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_item;
        end
    end

endmodule

>>> design/mdm_back.sv
module mdm_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  mdm_pkg::mdm_item_t      in_item,
    output logic                    in_rd,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [8:0]       left_front_cmd,
    output logic signed [8:0]       left_rear_cmd,
    output logic signed [8:0]       right_front_cmd,
    output logic signed [8:0]       right_rear_cmd
);

    typedef struct packed {
        mdm_pkg::mdm_mode_t mode;
        logic signed [8:0]  y;
        logic signed [8:0]  xg;
        logic [15:0]        prod;
        logic               div128;
        logic               sneg;
        logic               scale_en;
        logic               scale_left;
    } mdm_work_t;

    mdm_work_t          s1_reg;
    mdm_work_t          s1_next;
    logic               s1_v_reg;
    logic               out_v_reg;
    logic               out_free;
    logic               s1_load;
    logic [7:0]         ymag;
    logic [16:0]        q255_sum;
    logic [7:0]         qmag;
    logic signed [8:0]  scaled;
    logic signed [8:0]  left;
    logic signed [8:0]  right;
    logic signed [8:0]  lf_next;
    logic signed [8:0]  lr_next;
    logic signed [8:0]  rf_next;
    logic signed [8:0]  rr_next;
    logic signed [8:0]  lf_reg;
    logic signed [8:0]  lr_reg;
    logic signed [8:0]  rf_reg;
    logic signed [8:0]  rr_reg;

    // Stall control for the two stages
    assign out_free = !out_v_reg || pop;
    assign s1_load  = !s1_v_reg || out_free;
    assign in_rd    = in_valid && s1_load;
    assign empty    = !out_v_reg;

    // Stage 1: multiply the magnitude of y by the side factor
    always_comb
    begin
        ymag               = in_item.y[8] ? 8'(-in_item.y) : in_item.y[7:0];
        s1_next.mode       = in_item.mode;
        s1_next.y          = in_item.y;
        s1_next.xg         = in_item.xg;
        s1_next.prod       = ymag * in_item.factor;
        s1_next.div128     = in_item.div128;
        s1_next.sneg       = in_item.y[8] ^ in_item.neg;
        s1_next.scale_en   = in_item.scale_en;
        s1_next.scale_left = in_item.scale_left;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_rd)
        begin
            s1_reg <= s1_next;
        end
    end

    // Stage 2: divide with truncation toward zero, then map to the wheels
    always_comb
    begin
        // floor(p / 255) is exact as (p + (p >> 8) + 1) >> 8 for p up to 255 * 255
        q255_sum = {1'b0, s1_reg.prod} + {9'd0, s1_reg.prod[15:8]} + 17'd1;
        qmag     = s1_reg.div128 ? s1_reg.prod[14:7] : q255_sum[15:8];
        scaled   = s1_reg.sneg ? 9'(-{1'b0, qmag}) : $signed({1'b0, qmag});
        left     = (s1_reg.scale_en && s1_reg.scale_left) ? scaled : s1_reg.y;
        right    = (s1_reg.scale_en && !s1_reg.scale_left) ? scaled : s1_reg.y;

        case (s1_reg.mode)
            mdm_pkg::MODE_SPIN:
            begin
                lf_next = -s1_reg.xg;
                lr_next = -s1_reg.xg;
                rf_next = s1_reg.xg;
                rr_next = s1_reg.xg;
            end
            mdm_pkg::MODE_SLIDE:
            begin
                lf_next = s1_reg.xg;
                rf_next = s1_reg.xg;
                lr_next = -s1_reg.xg;
                rr_next = -s1_reg.xg;
            end
            mdm_pkg::MODE_VEER:
            begin
                lf_next = left;
                lr_next = left;
                rf_next = right;
                rr_next = right;
            end
            default:
            begin
                if (!s1_reg.y[8])
                begin
                    lf_next = left;
                    lr_next = right;
                    rr_next = left;
                    rf_next = right;
                end
                else
                begin
                    lf_next = right;
                    lr_next = left;
                    rr_next = right;
                    rf_next = left;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_v_reg <= s1_v_reg;
        end
    end

    // Hold the result until it is popped
    always_ff @(posedge clk)
    begin
        if (out_free && s1_v_reg)
        begin
            lf_reg <= lf_next;
            lr_reg <= lr_next;
            rf_reg <= rf_next;
            rr_reg <= rr_next;
        end
    end

    assign left_front_cmd  = lf_reg;
    assign left_rear_cmd   = lr_reg;
    assign right_front_cmd = rf_reg;
    assign right_rear_cmd  = rr_reg;

endmodule

>>> design/mecanum_drive_mixer.sv
// Path: an accepted item passes through the queue, the stage-1 register and the output
// register before its result shows (empty low).
// Throughput: one item per cycle; the front-to-back queue (QUEUE_DEPTH items) and the
// two back stages absorb stalls, so full rises only when all of them are occupied.
// Reset: rst_n clears the queue and both back stages and sets the governor limit to 255, as for 100 percent.
module mecanum_drive_mixer
#(
    parameter int QUEUE_DEPTH = mdm_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                max_speed_percent_wr,
    input  logic [6:0]          max_speed_percent,
    input  logic                push,
    output logic                full,
    input  logic signed [15:0]  axis_x,
    input  logic signed [15:0]  axis_y,
    input  logic                strafe_mode,
    output logic                empty,
    input  logic                pop,
    output logic signed [8:0]   left_front_cmd,
    output logic signed [8:0]   left_rear_cmd,
    output logic signed [8:0]   right_front_cmd,
    output logic signed [8:0]   right_rear_cmd
);

    logic                   item_wr;
    mdm_pkg::mdm_item_t     front_item;
    logic                   q_valid;
    logic                   q_rd;
    mdm_pkg::mdm_item_t     q_item;

    // Clamp, govern and classify
    mdm_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (max_speed_percent_wr),
        .cfg_pct     (max_speed_percent),
        .push        (push),
        .full        (full),
        .axis_x      (axis_x),
        .axis_y      (axis_y),
        .strafe_mode (strafe_mode),
        .item_wr     (item_wr),
        .item        (front_item)
    );

    // Decouple front from back
    mdm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (item_wr),
        .wr_item  (front_item),
        .full     (full),
        .rd       (q_rd),
        .rd_valid (q_valid),
        .rd_item  (q_item)
    );

    // Scale and map to the wheels
    mdm_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (q_valid),
        .in_item         (q_item),
        .in_rd           (q_rd),
        .empty           (empty),
        .pop             (pop),
        .left_front_cmd  (left_front_cmd),
        .left_rear_cmd   (left_rear_cmd),
        .right_front_cmd (right_front_cmd),
        .right_rear_cmd  (right_rear_cmd)
    );

endmodule
